FILE: rtl/sgm_pkg.sv
// Shared widths, register indexes, Sobel weights and the window sum for the gradient block.
`timescale 1ns / 1ps

package sgm_pkg;

    // Field and internal widths fixed by the pixel and result formats.
    localparam int CH_W      = 8;
    localparam int PIX_W     = 10;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 8;
    localparam int EXT_W     = 14;
    localparam int ROW_IN_W  = 13;
    localparam int OUT_ROW_W = 12;
    localparam int OUT_COL_W = 11;
    localparam int MAG_W     = 17;
    localparam int G_W       = 13;
    localparam int ABS_W     = 12;
    localparam int SQ_W      = 25;
    localparam int TAPS      = 9;

    // Frame size limits and reset values.
    localparam int MIN_SIZE     = 2;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

    // A 3x3 window in row-major order, top row first, newest column last.
    typedef logic [0:TAPS-1][PIX_W-1:0] window_t;
    typedef logic [0:TAPS-1][2:0] weights_t;

    // Horizontal kernel: left column minus right column.
    localparam weights_t SOBEL_WX = '{
        3'sd1, 3'sd0, -3'sd1,
        3'sd2, 3'sd0, -3'sd2,
        3'sd1, 3'sd0, -3'sd1
    };

    // Vertical kernel: top row minus bottom row.
    localparam weights_t SOBEL_WY = '{
        3'sd1, 3'sd2, 3'sd1,
        3'sd0, 3'sd0, 3'sd0,
        -3'sd1, -3'sd2, -3'sd1
    };

    // Weighted sum of one window; the result always fits in G_W signed bits.
    function automatic logic signed [G_W-1:0] sobel_sum(input window_t win, input weights_t k);
        logic signed [G_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < TAPS; i++) begin
            acc = acc + G_W'(signed'(k[i])) * signed'(G_W'(win[i]));
        end
        return acc;
    endfunction

endpackage

FILE: rtl/sobel_gradient_magnitude.sv
// Sobel gradient magnitude over a raster RGB stream: two line RAMs, a 3x3 window, serial root.
//
// Pixels enter on the s_ channel in raster order (s_kind 0); flush requests (s_kind 1)
// drain the last row once all pixels of the frame are in, and are dropped before that.
// Each result on the m_ channel belongs to the pixel one row plus one column earlier and
// carries its column, row and end-of-row and end-of-frame marks. The magnitude is
// floor(sqrt(gx^2 + gy^2)) with FRAC_BITS fraction bits. image_width and image_height
// are written through the cfg_ channel, which is always ready; the user writes them only
// between frames, and the block itself does not enforce this. A request that yields no
// result passes through the update state only. One that yields a result also passes
// through the two squaring states, the root start state and the root wait state, where
// the bit-serial square root runs. The line RAMs are read in the accept cycle and written
// back in the cycle after, in the update state, before the next request can enter.
// The block takes the next request while a result still waits in the output register;
// a stalled receiver holds the block only when a second result is ready to be loaded.
// Reset clears the counters, the window and the output valid flag and sets the frame size
// to 640 by 480; the line RAMs need no clearing since rows above the frame read as zero.
`timescale 1ns / 1ps

module sobel_gradient_magnitude
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int FRAC_BITS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [CH_W-1:0]      s_red,
    input  logic [CH_W-1:0]      s_green,
    input  logic [CH_W-1:0]      s_blue,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [MAG_W-1:0]     m_magnitude,
    output logic [OUT_COL_W-1:0] m_out_column,
    output logic [OUT_ROW_W-1:0] m_out_row,
    output logic                 m_row_end,
    output logic                 m_frame_end,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROOT_W = (SQ_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_WIDTH);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_UPDATE    = 3'd1;
    localparam logic [2:0] ST_SQ_X      = 3'd2;
    localparam logic [2:0] ST_SQ_Y      = 3'd3;
    localparam logic [2:0] ST_ROOT_GO   = 3'd4;
    localparam logic [2:0] ST_ROOT_WAIT = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CFG_W-1:0]      width_reg, height_reg;

    logic [COL_W-1:0]      in_col_reg, in_col_next;
    logic [ROW_IN_W-1:0]   in_row_reg, in_row_next;
    logic [COL_W-1:0]      emit_col_reg, emit_col_next;
    logic [OUT_ROW_W-1:0]  emit_row_reg, emit_row_next;
    window_t               win_reg, win_next;

    logic                  kind_reg;
    logic [PIX_W-1:0]      bright_reg;
    logic signed [G_W-1:0] gx_reg, gy_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [COL_W-1:0]      info_col_reg;
    logic [OUT_ROW_W-1:0]  info_row_reg;
    logic                  info_row_end_reg;
    logic                  info_frame_end_reg;

    logic                  m_valid_reg;
    logic [MAG_W-1:0]      m_magnitude_reg;
    logic [OUT_COL_W-1:0]  m_out_column_reg;
    logic [OUT_ROW_W-1:0]  m_out_row_reg;
    logic                  m_row_end_reg;
    logic                  m_frame_end_reg;

    logic [EXT_W-1:0]      width_ext, w_eff;
    logic [CFG_W-1:0]      h_eff;
    logic [ROW_IN_W-1:0]   h_row;

    logic                  in_accept;
    logic                  ram_re, ram_we;
    logic [PIX_W-1:0]      rd_above, rd_two;

    logic                  draining, skip, is_pixel, in_frame, col_zero, emit;
    logic                  col_last, row_end, frame_end;
    logic [PIX_W-1:0]      top, mid, bot;
    logic [2:0][PIX_W-1:0] col_new;
    window_t               mag_win, shift_win;

    logic [ABS_W-1:0]      ax, ay, mul_a;
    logic [2*ABS_W-1:0]    prod;
    logic                  sqrt_start, sqrt_busy;
    logic [RAD_W-1:0]      radicand;
    logic [ROOT_W-1:0]     root;
    logic                  out_free, out_load;

    // Frame size registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(WIDTH_RESET);
            height_reg <= CFG_W'(HEIGHT_RESET);
        end else if (cfg_valid) begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                width_reg <= cfg_data;
            end else if (cfg_index == REG_IMAGE_HEIGHT) begin
                height_reg <= cfg_data;
            end
        end
    end

    // Effective frame size: both at least MIN_SIZE, the width clamped to what the line RAMs hold.
    assign width_ext = EXT_W'(width_reg);
    assign w_eff = (width_reg < CFG_W'(MIN_SIZE)) ? EXT_W'(MIN_SIZE) :
                   (width_ext > MAX_EXT) ? MAX_EXT : width_ext;
    assign h_eff = (height_reg < CFG_W'(MIN_SIZE)) ? CFG_W'(MIN_SIZE) : height_reg;
    assign h_row = ROW_IN_W'(h_eff);

    // Input side: one request at a time, read the line RAMs as it is taken.
    assign s_ready   = state_reg == ST_IDLE;
    assign in_accept = s_valid && s_ready;
    assign ram_re    = in_accept;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            kind_reg   <= s_kind;
            bright_reg <= PIX_W'(s_red) + PIX_W'(s_green) + PIX_W'(s_blue);
        end
    end

    sgm_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_above (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(in_col_reg),
        .wdata(bot),
        .re   (ram_re),
        .raddr(in_col_reg),
        .rdata(rd_above)
    );

    sgm_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_two_above (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(in_col_reg),
        .wdata(mid),
        .re   (ram_re),
        .raddr(in_col_reg),
        .rdata(rd_two)
    );

    // Classify the request and pick the new window column; rows above the frame read zero.
    assign draining = in_row_reg >= h_row;
    assign skip     = kind_reg && !draining;
    assign is_pixel = !kind_reg && !draining;
    assign in_frame = in_row_reg <= h_row;
    assign col_zero = in_col_reg == '0;
    assign emit     = col_zero ? (in_row_reg >= ROW_IN_W'(2)) : (in_row_reg >= ROW_IN_W'(1));

    assign top = (in_frame && in_row_reg >= ROW_IN_W'(2)) ? rd_two : '0;
    assign mid = (in_frame && in_row_reg >= ROW_IN_W'(1)) ? rd_above : '0;
    assign bot = is_pixel ? bright_reg : '0;
    assign col_new = {bot, mid, top};

    assign ram_we = (state_reg == ST_UPDATE) && !skip && in_frame;

    // Shifted window and the window the magnitude is taken from.
    // At the first column the old window is the right edge of the previous row.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            mag_win[r*3]     = win_reg[r*3+1];
            mag_win[r*3+1]   = win_reg[r*3+2];
            mag_win[r*3+2]   = col_zero ? '0 : col_new[r];
            shift_win[r*3]   = col_zero ? '0 : win_reg[r*3+1];
            shift_win[r*3+1] = col_zero ? '0 : win_reg[r*3+2];
            shift_win[r*3+2] = col_new[r];
        end
    end

    // Position bookkeeping for the input and result sides.
    assign col_last  = (EXT_W'(in_col_reg) + EXT_W'(1)) >= w_eff;
    assign row_end   = EXT_W'(emit_col_reg) >= (w_eff - EXT_W'(1));
    assign frame_end = row_end && (emit_row_reg >= (h_eff - CFG_W'(1)));

    always_comb begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        emit_col_next = emit_col_reg;
        emit_row_next = emit_row_reg;
        win_next      = win_reg;
        if (state_reg == ST_UPDATE && !skip) begin
            win_next = shift_win;
            if (col_last) begin
                in_col_next = '0;
                if (in_row_reg != '1) begin
                    in_row_next = in_row_reg + 1'b1;
                end
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (emit) begin
                if (frame_end) begin
                    in_col_next   = '0;
                    in_row_next   = '0;
                    emit_col_next = '0;
                    emit_row_next = '0;
                    win_next      = '0;
                end else if (row_end) begin
                    emit_col_next = '0;
                    emit_row_next = emit_row_reg + 1'b1;
                end else begin
                    emit_col_next = emit_col_reg + 1'b1;
                end
            end
        end
    end

    // Gradient sums and result position are captured with the window update.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPDATE) begin
            gx_reg <= sobel_sum(mag_win, SOBEL_WX);
            gy_reg <= sobel_sum(mag_win, SOBEL_WY);
            if (emit) begin
                info_col_reg       <= emit_col_reg;
                info_row_reg       <= emit_row_reg;
                info_row_end_reg   <= row_end;
                info_frame_end_reg <= frame_end;
            end
        end
    end

    // Sum of squares through one shared multiplier: gx squared in ST_SQ_X, gy squared added in ST_SQ_Y.
    assign ax    = gx_reg[G_W-1] ? ABS_W'(-gx_reg) : ABS_W'(gx_reg);
    assign ay    = gy_reg[G_W-1] ? ABS_W'(-gy_reg) : ABS_W'(gy_reg);
    assign mul_a = (state_reg == ST_SQ_X) ? ax : ay;
    assign prod  = mul_a * mul_a;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SQ_X) begin
            sq_reg <= SQ_W'(prod);
        end else if (state_reg == ST_SQ_Y) begin
            sq_reg <= sq_reg + SQ_W'(prod);
        end
    end

    // Square root of the fraction-scaled sum.
    assign sqrt_start = state_reg == ST_ROOT_GO;
    assign radicand   = RAD_W'(sq_reg) << (2 * FRAC_BITS);

    sgm_sqrt #(
        .ROOT_W(ROOT_W)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .radicand(radicand),
        .busy    (sqrt_busy),
        .root    (root)
    );

    // Sequencer.
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_ROOT_WAIT) && !sqrt_busy && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = (!skip && emit) ? ST_SQ_X : ST_IDLE;
            end
            ST_SQ_X: begin
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO: begin
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
            win_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            emit_col_reg <= emit_col_next;
            emit_row_reg <= emit_row_next;
            win_reg      <= win_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_magnitude_reg  <= MAG_W'(root);
            m_out_column_reg <= OUT_COL_W'(info_col_reg);
            m_out_row_reg    <= info_row_reg;
            m_row_end_reg    <= info_row_end_reg;
            m_frame_end_reg  <= info_frame_end_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_magnitude  = m_magnitude_reg;
    assign m_out_column = m_out_column_reg;
    assign m_out_row    = m_out_row_reg;
    assign m_row_end    = m_row_end_reg;
    assign m_frame_end  = m_frame_end_reg;

`ifndef ASSERT_OFF
    // A line RAM write-back always follows the read of the same request.
    a_write_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> $past(ram_re))
        else $error("line RAM written without a preceding read");

    // The root unit only starts from the start state of the sequencer.
    a_root_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(sqrt_busy) |-> $past(state_reg) == ST_ROOT_GO)
        else $error("square root started outside the sequencer");

    // A new request is never taken while the root unit is still working.
    a_ready_idle_root: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sqrt_busy)
        else $error("request accepted while square root busy");

    // By the time a frame-end result is loaded, the counters have returned to zero.
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && info_frame_end_reg) |-> (in_row_reg == '0 && in_col_reg == '0))
        else $error("counters not cleared at frame end");
`endif

endmodule

FILE: rtl/sgm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module sgm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read share the clock; read data is registered and shows in the cycle after the address.
    always_ff @(posedge aclk) begin
        if (we) begin
            store_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sgm_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps

module sgm_sqrt #(
    parameter int ROOT_W = 17
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic                  busy,
    output logic [ROOT_W-1:0]     root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              take;

    // Bring down the next two radicand bits and test the candidate root bit.
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});
    assign take      = rem_shift >= trial;

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_W'(ROOT_W);
        end else if (busy_reg) begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: the remainder always stays at or below twice the partial root.
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? rem_shift - trial : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

FILE: bench/sobel_gradient_magnitude_test.sv
// Self-checking bench for the Sobel gradient magnitude block: directed, extreme and random frames.
`timescale 1ns / 1ps

module sobel_gradient_magnitude_test
    import sgm_pkg::*;
();

    localparam int LINE_DEPTH    = 2048;
    localparam int FRACTION_BITS = 4;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 710;
    localparam longint TIMEOUT_NS = 200_000_000;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum int {
        PAT_RANDOM,
        PAT_EXTREME,
        PAT_CHECKER,
        PAT_STRIPES,
        PAT_FLAT
    } pattern_e;

    typedef struct {
        logic [MAG_W-1:0]     magnitude;
        logic [OUT_COL_W-1:0] column;
        logic [OUT_ROW_W-1:0] row;
        logic                 row_end;
        logic                 frame_end;
    } gradient_result_t;

    // Block ports; the inputs are known from time zero.
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_kind = KIND_PIXEL;
    logic [CH_W-1:0]      s_red = '0;
    logic [CH_W-1:0]      s_green = '0;
    logic [CH_W-1:0]      s_blue = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [MAG_W-1:0]     m_magnitude;
    logic [OUT_COL_W-1:0] m_out_column;
    logic [OUT_ROW_W-1:0] m_out_row;
    logic                 m_row_end;
    logic                 m_frame_end;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Predictor state: frame size, line stores, window and positions.
    logic [CFG_W-1:0] width_reg = CFG_W'(WIDTH_RESET);
    logic [CFG_W-1:0] height_reg = CFG_W'(HEIGHT_RESET);
    logic [PIX_W-1:0] line_above [LINE_DEPTH];
    logic [PIX_W-1:0] line_two_above [LINE_DEPTH];
    window_t          win_taps = '0;
    int unsigned      col_in = 0;
    int unsigned      row_in = 0;
    int unsigned      col_out = 0;
    int unsigned      row_out = 0;

    gradient_result_t pending_results [$];
    gradient_result_t next_result;

    int mismatch_count  = 0;
    int results_checked = 0;
    int counted_items   = 0;
    int frames_sent     = 0;
    int ready_hold      = 0;
    int ready_pick;

    sobel_gradient_magnitude #(
        .MAX_WIDTH (LINE_DEPTH),
        .FRAC_BITS (FRACTION_BITS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_magnitude  (m_magnitude),
        .m_out_column (m_out_column),
        .m_out_row    (m_out_row),
        .m_row_end    (m_row_end),
        .m_frame_end  (m_frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Effective frame size after saturation of the registers.
    function automatic int unsigned frame_width();
        int unsigned w;
        w = (width_reg < MIN_SIZE) ? MIN_SIZE : width_reg;
        if (w > LINE_DEPTH) begin
            w = LINE_DEPTH;
        end
        return w;
    endfunction

    function automatic int unsigned frame_height();
        return (height_reg < MIN_SIZE) ? MIN_SIZE : height_reg;
    endfunction

    // Floored magnitude of the Sobel sums of one window, found bit by bit.
    function automatic logic [MAG_W-1:0] gradient_of(input window_t t);
        int gx;
        int gy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned trial;
        gx = int'(t[0]) + 2 * int'(t[3]) + int'(t[6])
           - int'(t[2]) - 2 * int'(t[5]) - int'(t[8]);
        gy = int'(t[0]) + 2 * int'(t[1]) + int'(t[2])
           - int'(t[6]) - 2 * int'(t[7]) - int'(t[8]);
        ax = longint'(gx < 0 ? -gx : gx);
        ay = longint'(gy < 0 ? -gy : gy);
        sq = (ax * ax + ay * ay) << (2 * FRACTION_BITS);
        root = 0;
        for (int b = 20; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq) begin
                root = trial;
            end
        end
        return MAG_W'(root);
    endfunction

    // Advance the predictor by one accepted request and queue the result it causes.
    function automatic void predict_request(input logic kind, input logic [CH_W-1:0] red,
                                            input logic [CH_W-1:0] green,
                                            input logic [CH_W-1:0] blue);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        int unsigned idx;
        int unsigned top;
        int unsigned mid;
        int unsigned bot;
        bit draining;
        bit emit;
        bit rend;
        bit fend;
        logic [MAG_W-1:0] mag;
        window_t shifted;
        gradient_result_t res;
        w = frame_width();
        h = frame_height();
        draining = row_in >= h;
        // A flush before the frame's last pixel is dropped.
        if (kind == KIND_FLUSH && !draining) begin
            return;
        end
        col = col_in;
        row = row_in;
        idx = col % LINE_DEPTH;
        top = 0;
        mid = 0;
        bot = 0;
        if (row <= h) begin
            if (row >= 2) begin
                top = line_two_above[idx];
            end
            if (row >= 1) begin
                mid = line_above[idx];
            end
        end
        // A pixel while draining acts as a flush.
        if (kind == KIND_PIXEL && !draining) begin
            bot = int'(red) + int'(green) + int'(blue);
        end
        mag = '0;
        if (col == 0) begin
            // The last column of the previous row sees zeros on its right.
            emit = row >= 2;
            for (int k = 0; k < 3; k++) begin
                shifted[k * 3]     = win_taps[k * 3 + 1];
                shifted[k * 3 + 1] = win_taps[k * 3 + 2];
                shifted[k * 3 + 2] = '0;
            end
            if (emit) begin
                mag = gradient_of(shifted);
            end
            win_taps = '0;
        end else begin
            emit = row >= 1;
            for (int k = 0; k < 3; k++) begin
                win_taps[k * 3]     = win_taps[k * 3 + 1];
                win_taps[k * 3 + 1] = win_taps[k * 3 + 2];
            end
        end
        win_taps[2] = PIX_W'(top);
        win_taps[5] = PIX_W'(mid);
        win_taps[8] = PIX_W'(bot);
        if (col != 0 && emit) begin
            mag = gradient_of(win_taps);
        end
        if (row <= h) begin
            line_two_above[idx] = PIX_W'(mid);
            line_above[idx]     = PIX_W'(bot);
        end
        if (col + 1 >= w) begin
            col_in = 0;
            row_in = row_in + 1;
        end else begin
            col_in = col + 1;
        end
        if (!emit) begin
            return;
        end
        rend = col_out >= w - 1;
        fend = rend && (row_out >= h - 1);
        res.magnitude = mag;
        res.column    = OUT_COL_W'(col_out);
        res.row       = OUT_ROW_W'(row_out);
        res.row_end   = rend;
        res.frame_end = fend;
        pending_results.push_back(res);
        // Positions and window start over after the frame's last result.
        if (fend) begin
            col_in   = 0;
            row_in   = 0;
            col_out  = 0;
            row_out  = 0;
            win_taps = '0;
        end else if (rend) begin
            col_out = 0;
            row_out = row_out + 1;
        end else begin
            col_out = col_out + 1;
        end
    endfunction

    // Sender gap before a request: mostly none or short, now and then long.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) begin
            return 0;
        end else if (p < 85) begin
            return $urandom_range(1, 2);
        end else if (p < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void make_pixel(input pattern_e pat, input int unsigned col,
                                       input int unsigned row, output logic [CH_W-1:0] red,
                                       output logic [CH_W-1:0] green,
                                       output logic [CH_W-1:0] blue);
        logic [CH_W-1:0] v;
        case (pat)
            PAT_RANDOM: begin
                red   = CH_W'($urandom_range(0, 255));
                green = CH_W'($urandom_range(0, 255));
                blue  = CH_W'($urandom_range(0, 255));
            end
            PAT_EXTREME: begin
                red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: begin
                if (pat == PAT_CHECKER) begin
                    v = ((col + row) % 2 != 0) ? 8'hFF : 8'h00;
                end else if (pat == PAT_STRIPES) begin
                    v = (col % 2 != 0) ? 8'h00 : 8'hFF;
                end else begin
                    v = 8'hFF;
                end
                red   = v;
                green = v;
                blue  = v;
            end
        endcase
    endfunction

    // Send one request on the pixel channel and predict once it is accepted.
    task automatic send_item(input logic kind, input logic [CH_W-1:0] red,
                             input logic [CH_W-1:0] green, input logic [CH_W-1:0] blue);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_red   <= red;
        s_green <= green;
        s_blue  <= blue;
        do @(posedge aclk); while (!s_ready);
        predict_request(kind, red, green, blue);
    endtask

    // Let every expected result arrive, then give the block time to settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Hold cfg_valid high across back-to-back writes; the caller lowers it.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == REG_IMAGE_WIDTH) begin
            width_reg = value;
        end else if (index == REG_IMAGE_HEIGHT) begin
            height_reg = value;
        end
    endtask

    // Change the frame size between frames, optionally with a write to an unused index.
    task automatic set_frame_size(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
                                  input bit add_stray);
        wait_idle();
        if (add_stray) begin
            write_register(CFG_IDX_W'($urandom_range(2, 255)), CFG_W'($urandom_range(0, 4095)));
        end
        write_register(REG_IMAGE_WIDTH, width);
        write_register(REG_IMAGE_HEIGHT, height);
        cfg_valid <= 1'b0;
    endtask

    // One whole frame plus its drain; noisy frames add dropped flushes and drain pixels.
    task automatic send_frame(input pattern_e pat, input bit noisy);
        int unsigned w;
        int unsigned h;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        w = frame_width();
        h = frame_height();
        for (int unsigned i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                send_item(KIND_FLUSH, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
            end
            make_pixel(pat, i % w, i / w, r, g, b);
            send_item(KIND_PIXEL, r, g, b);
            counted_items++;
        end
        for (int unsigned i = 0; i <= w; i++) begin
            send_item((noisy && $urandom_range(0, 3) == 0) ? KIND_PIXEL : KIND_FLUSH,
                      CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
            counted_items++;
        end
        frames_sent++;
    endtask

    // Smallest frame from saturated register values, with a dropped flush at the
    // frame start and mid-frame, and a pixel in the drain.
    task automatic test_saturated_small_frame();
        set_frame_size(12'd0, 12'd1, 1'b0);
        send_item(KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        send_item(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
        send_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_item(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
        send_item(KIND_PIXEL, 8'hFF, 8'h00, 8'hFF);
        send_item(KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        counted_items += 7;
        frames_sent++;
    endtask

    // Strong vertical edges in a three-wide frame.
    task automatic test_stripes();
        set_frame_size(12'd3, 12'd2, 1'b1);
        send_frame(PAT_STRIPES, 1'b0);
    endtask

    // A wide, short frame of extreme values and a narrow, tall frame whose width
    // saturates from below.
    task automatic test_size_extremes();
        set_frame_size(12'd160, 12'd2, 1'b1);
        send_frame(PAT_EXTREME, 1'b0);
        set_frame_size(12'd1, 12'd120, 1'b0);
        send_frame(PAT_RANDOM, 1'b0);
    endtask

    // Random small frames; most are clean, some carry noise, some follow back to back.
    task automatic test_random_frames();
        int target;
        int p;
        bit first;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        target = counted_items + RANDOM_ITEMS;
        first = 1'b1;
        while (counted_items < target) begin
            if (first || $urandom_range(0, 9) < 7) begin
                p = $urandom_range(0, 99);
                w = (p < 8) ? CFG_W'($urandom_range(0, 1)) :
                    (p < 90) ? CFG_W'($urandom_range(2, 10)) : CFG_W'($urandom_range(11, 40));
                p = $urandom_range(0, 99);
                h = (p < 8) ? CFG_W'($urandom_range(0, 1)) :
                    (p < 92) ? CFG_W'($urandom_range(2, 8)) : CFG_W'($urandom_range(9, 20));
                set_frame_size(w, h, $urandom_range(0, 3) == 0);
                first = 1'b0;
            end
            send_frame(pattern_e'($urandom_range(0, 4)), $urandom_range(0, 4) == 0);
        end
    endtask

    // Receiver: ready runs and stalls of random length, including long clean stretches.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 50) begin
                m_ready <= 1'b1;
                ready_hold = $urandom_range(0, 7);
            end else if (ready_pick < 60) begin
                m_ready <= 1'b1;
                ready_hold = $urandom_range(50, 300);
            end else if (ready_pick < 90) begin
                m_ready <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end else if (ready_pick < 98) begin
                m_ready <= 1'b0;
                ready_hold = $urandom_range(3, 14);
            end else begin
                m_ready <= 1'b0;
                ready_hold = $urandom_range(29, 79);
            end
        end
    end

    function automatic void report_mismatch(input string field, input logic [31:0] want,
                                            input logic [31:0] got);
        mismatch_count++;
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    endfunction

    // Compare each accepted result with the oldest expected one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $error("result at column %0d row %0d arrived with none expected",
                       m_out_column, m_out_row);
            end else begin
                next_result = pending_results.pop_front();
                results_checked++;
                if (m_magnitude !== next_result.magnitude) begin
                    report_mismatch("magnitude", 32'(next_result.magnitude), 32'(m_magnitude));
                end
                if (m_out_column !== next_result.column) begin
                    report_mismatch("out_column", 32'(next_result.column), 32'(m_out_column));
                end
                if (m_out_row !== next_result.row) begin
                    report_mismatch("out_row", 32'(next_result.row), 32'(m_out_row));
                end
                if (m_row_end !== next_result.row_end) begin
                    report_mismatch("row_end", 32'(next_result.row_end), 32'(m_row_end));
                end
                if (m_frame_end !== next_result.frame_end) begin
                    report_mismatch("frame_end", 32'(next_result.frame_end), 32'(m_frame_end));
                end
            end
        end
    end

    // Run limit for a hung block.
    initial begin
        #(TIMEOUT_NS);
        $display("sobel_gradient_magnitude verification failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_saturated_small_frame();
        test_stripes();
        test_size_extremes();
        test_random_frames();
        wait_idle();
        $display("Covered %0d frames with %0d pixel and drain requests; %0d results checked.",
                 frames_sent, counted_items, results_checked);
        $display("Sizes ranged from 2x2 up to 160 wide and 120 tall, with saturated values.");
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("sobel_gradient_magnitude verification clean");
        end else begin
            $display("sobel_gradient_magnitude verification failed");
        end
        $finish;
    end

endmodule
